// ===== sv/vn3_pkg.sv =====
// Shared types and sizes for the 3D vector normalizer.
// Holds the component width, pipeline widths and the payload structs.
// No dependencies.
`default_nettype none
package vn3_pkg;

	// Input component width (signed Q15.16 at the default of 32).
	localparam int unsigned COMP_W = 32;

	// Fixed output widths.
	localparam int unsigned UNIT_W = 32;
	localparam int unsigned LEN_W  = 32;

	// Sum of squares scaled by 2^32, root with 16 extra fraction bits.
	localparam int unsigned RAD_SHIFT = 32;
	localparam int unsigned RAD_W     = 2 * COMP_W + RAD_SHIFT;
	localparam int unsigned ROOT_W    = RAD_W / 2;
	localparam int unsigned REM_W     = ROOT_W + 2;

	// Root fraction bits beyond Q16.16.
	localparam int unsigned ROOT_FRAC = 16;

	// Unit component: magnitude * 2^46 / root, quotient of at most 2^30.
	localparam int unsigned NUM_SHIFT = 46;
	localparam int unsigned NUM_W     = COMP_W + NUM_SHIFT;
	localparam int unsigned QUO_W     = 31;

	// Length before saturation.
	localparam int unsigned LENX_W = (COMP_W > LEN_W) ? COMP_W : LEN_W;

	typedef struct packed {
		logic signed [COMP_W-1:0] comp_x;
		logic signed [COMP_W-1:0] comp_y;
		logic signed [COMP_W-1:0] comp_z;
	} vec_in_t;

	typedef struct packed {
		logic signed [UNIT_W-1:0] unit_x;
		logic signed [UNIT_W-1:0] unit_y;
		logic signed [UNIT_W-1:0] unit_z;
		logic [LEN_W-1:0]         length;
		logic                     zero_vector;
	} vec_out_t;

	// Per-item data that rides alongside the root and divide stages.
	typedef struct packed {
		logic [2:0]        neg;
		logic [COMP_W-1:0] mag_x;
		logic [COMP_W-1:0] mag_y;
		logic [COMP_W-1:0] mag_z;
		logic              zero;
	} side_t;

	// Pipeline control shared by all stage modules.
	typedef struct packed {
		logic en;
	} pipe_ctl_t;

endpackage
`default_nettype wire

// ===== sv/vn3_sumsq.sv =====
// Front end of the normalizer: magnitudes, squares and the scaled sum.
// Three register stages. Depends on vn3_pkg.
`default_nettype none
module vn3_sumsq (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire vn3_pkg::pipe_ctl_t      ctl,
	input  wire logic                    in_vld,
	input  wire vn3_pkg::vec_in_t        in_vec,
	output logic                         out_vld,
	output logic [vn3_pkg::RAD_W-1:0]    out_rad,
	output vn3_pkg::side_t               out_side
);

	localparam int unsigned W  = vn3_pkg::COMP_W;
	localparam int unsigned SW = 2 * W;

	logic             vld_s1, vld_s2, vld_s3;
	vn3_pkg::side_t   side_s1, side_s2, side_s3;
	logic [SW-1:0]    sq_x_s2, sq_y_s2, sq_z_s2;
	logic [vn3_pkg::RAD_W-1:0] rad_s3;

	logic [W-1:0] mag_x, mag_y, mag_z;
	logic [SW-1:0] sum_sq;

	// Take absolute values; the most negative code keeps its full size
	always_comb begin
		mag_x = in_vec.comp_x[W-1] ? W'(-in_vec.comp_x) : W'(in_vec.comp_x);
		mag_y = in_vec.comp_y[W-1] ? W'(-in_vec.comp_y) : W'(in_vec.comp_y);
		mag_z = in_vec.comp_z[W-1] ? W'(-in_vec.comp_z) : W'(in_vec.comp_z);
	end

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (ctl.en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Stage 1: register magnitudes, signs and the zero flag
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			side_s1.mag_x <= mag_x;
			side_s1.mag_y <= mag_y;
			side_s1.mag_z <= mag_z;
			side_s1.neg   <= {in_vec.comp_x[W-1], in_vec.comp_y[W-1], in_vec.comp_z[W-1]};
			side_s1.zero  <= (in_vec.comp_x == '0) && (in_vec.comp_y == '0)
				&& (in_vec.comp_z == '0);
		end
	end

	// Stage 2: one multiplier per component
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			sq_x_s2 <= SW'(side_s1.mag_x) * SW'(side_s1.mag_x);
			sq_y_s2 <= SW'(side_s1.mag_y) * SW'(side_s1.mag_y);
			sq_z_s2 <= SW'(side_s1.mag_z) * SW'(side_s1.mag_z);
			side_s2 <= side_s1;
		end
	end

	// Stage 3: sum of squares, below 2^(2W) so it cannot overflow
	assign sum_sq = sq_x_s2 + sq_y_s2 + sq_z_s2;

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			rad_s3  <= {sum_sq, {vn3_pkg::RAD_SHIFT{1'b0}}};
			side_s3 <= side_s2;
		end
	end

	assign out_vld  = vld_s3;
	assign out_rad  = rad_s3;
	assign out_side = side_s3;

endmodule
`default_nettype wire

// ===== sv/vn3_sqrt.sv =====
// Pipelined integer square root, one root bit per register stage.
// Restoring digit-by-digit method on bit pairs. Depends on vn3_pkg.
`default_nettype none
module vn3_sqrt (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire vn3_pkg::pipe_ctl_t       ctl,
	input  wire logic                     in_vld,
	input  wire logic [vn3_pkg::RAD_W-1:0] in_rad,
	input  wire vn3_pkg::side_t           in_side,
	output logic                          out_vld,
	output logic [vn3_pkg::ROOT_W-1:0]    out_root,
	output vn3_pkg::side_t                out_side
);

	localparam int unsigned N  = vn3_pkg::ROOT_W;
	localparam int unsigned RW = vn3_pkg::RAD_W;
	localparam int unsigned MW = vn3_pkg::REM_W;

	logic            vld_s  [1:N];
	logic [RW-1:0]   rad_s  [1:N];
	logic [MW-1:0]   rem_s  [1:N];
	logic [N-1:0]    root_s [1:N];
	vn3_pkg::side_t  side_s [1:N];

	for (genvar g = 0; g < N; g++) begin : g_stage
		logic           vld_in;
		logic [RW-1:0]  rad_in;
		logic [MW-1:0]  rem_in;
		logic [N-1:0]   root_in;
		vn3_pkg::side_t side_in;
		logic [MW-1:0]  rem_sh, trial;
		logic           fit;

		// Select the previous stage, or the block input for the first one
		if (g == 0) begin : g_first
			assign vld_in  = in_vld;
			assign rad_in  = in_rad;
			assign rem_in  = '0;
			assign root_in = '0;
			assign side_in = in_side;
		end else begin : g_next
			assign vld_in  = vld_s[g];
			assign rad_in  = rad_s[g];
			assign rem_in  = rem_s[g];
			assign root_in = root_s[g];
			assign side_in = side_s[g];
		end

		// Bring down the next bit pair and try 4*root + 1
		assign rem_sh = {rem_in[MW-3:0], rad_in[RW-1 -: 2]};
		assign trial  = {root_in, 2'b01};
		assign fit    = rem_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (ctl.en) begin
				vld_s[g+1] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				rad_s[g+1]  <= {rad_in[RW-3:0], 2'b00};
				rem_s[g+1]  <= fit ? (rem_sh - trial) : rem_sh;
				root_s[g+1] <= {root_in[N-2:0], fit};
				side_s[g+1] <= side_in;
			end
		end
	end

	assign out_vld  = vld_s[N];
	assign out_root = root_s[N];
	assign out_side = side_s[N];

endmodule
`default_nettype wire

// ===== sv/vn3_div.sv =====
// Pipelined restoring divider, three lanes sharing one divisor.
// Each stage settles one quotient bit of magnitude * 2^46 / root. Depends on vn3_pkg.
`default_nettype none
module vn3_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire vn3_pkg::pipe_ctl_t        ctl,
	input  wire logic                      in_vld,
	input  wire logic [vn3_pkg::ROOT_W-1:0] in_root,
	input  wire vn3_pkg::side_t            in_side,
	output logic                           out_vld,
	output logic [vn3_pkg::ROOT_W-1:0]     out_root,
	output vn3_pkg::side_t                 out_side,
	output logic [vn3_pkg::QUO_W-1:0]      out_quo [3]
);

	localparam int unsigned N  = vn3_pkg::QUO_W;
	localparam int unsigned DW = vn3_pkg::NUM_W;
	localparam int unsigned RW = vn3_pkg::ROOT_W;

	logic            vld_s  [1:N];
	logic [RW-1:0]   root_s [1:N];
	vn3_pkg::side_t  side_s [1:N];
	logic [DW-1:0]   rem_s  [1:N][3];
	logic [N-1:0]    quo_s  [1:N][3];

	logic [DW-1:0]   num [3];

	// Scale the magnitudes into the dividends
	assign num[0] = DW'(in_side.mag_x) << vn3_pkg::NUM_SHIFT;
	assign num[1] = DW'(in_side.mag_y) << vn3_pkg::NUM_SHIFT;
	assign num[2] = DW'(in_side.mag_z) << vn3_pkg::NUM_SHIFT;

	for (genvar g = 0; g < N; g++) begin : g_stage
		localparam int unsigned BIT = N - 1 - g;
		logic           vld_in;
		logic [RW-1:0]  root_in;
		vn3_pkg::side_t side_in;
		logic [DW-1:0]  dsr;

		if (g == 0) begin : g_first
			assign vld_in  = in_vld;
			assign root_in = in_root;
			assign side_in = in_side;
		end else begin : g_next
			assign vld_in  = vld_s[g];
			assign root_in = root_s[g];
			assign side_in = side_s[g];
		end

		// Divisor aligned to this stage's quotient bit
		assign dsr = DW'(root_in) << BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (ctl.en) begin
				vld_s[g+1] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				root_s[g+1] <= root_in;
				side_s[g+1] <= side_in;
			end
		end

		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic [DW-1:0] rem_in;
			logic [N-1:0]  quo_in;
			logic          fit;

			if (g == 0) begin : g_first
				assign rem_in = num[l];
				assign quo_in = '0;
			end else begin : g_next
				assign rem_in = rem_s[g][l];
				assign quo_in = quo_s[g][l];
			end

			// Subtract the aligned divisor when it fits
			assign fit = rem_in >= dsr;

			always_ff @(posedge clk) begin
				if (ctl.en) begin
					rem_s[g+1][l] <= fit ? (rem_in - dsr) : rem_in;
					quo_s[g+1][l] <= {quo_in[N-2:0], fit};
				end
			end
		end
	end

	assign out_vld  = vld_s[N];
	assign out_root = root_s[N];
	assign out_side = side_s[N];

	for (genvar l = 0; l < 3; l++) begin : g_out
		assign out_quo[l] = quo_s[N][l];
	end

endmodule
`default_nettype wire

// ===== sv/vector_normalize_3d.sv =====
// Top level of the 3D vector normalizer: length and unit vector.
// Instantiates vn3_sumsq, vn3_sqrt and vn3_div; depends on vn3_pkg.
//
//   Channel   Signals                          Payload
//   input     in_valid / in_ready / in_data    vn3_pkg::vec_in_t  (comp_x, comp_y, comp_z)
//   output    out_valid / out_ready / out_data vn3_pkg::vec_out_t (unit_*, length, zero_vector)
//
// One vector enters per cycle while the output is not stalled; the path runs
// through three front stages, one stage per root bit, one stage per quotient
// bit, and the output register.
// Reset clears only the stage valid bits; data registers are not reset.
// A stalled output freezes the whole pipeline, so nothing is dropped or repeated.
`default_nettype none
module vector_normalize_3d (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire vn3_pkg::vec_in_t    in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output vn3_pkg::vec_out_t        out_data
);

	localparam int unsigned RW = vn3_pkg::ROOT_W;
	localparam int unsigned UW = vn3_pkg::UNIT_W;
	localparam int unsigned XW = vn3_pkg::LENX_W;

	vn3_pkg::pipe_ctl_t ctl;

	logic                    sq_vld;
	logic [vn3_pkg::RAD_W-1:0] sq_rad;
	vn3_pkg::side_t          sq_side;

	logic                    rt_vld;
	logic [RW-1:0]           rt_root;
	vn3_pkg::side_t          rt_side;

	logic                    dv_vld;
	logic [RW-1:0]           dv_root;
	vn3_pkg::side_t          dv_side;
	logic [vn3_pkg::QUO_W-1:0] dv_quo [3];

	logic                    out_vld_q;
	vn3_pkg::vec_out_t       out_q;
	vn3_pkg::vec_out_t       fmt;

	logic [XW-1:0]           len_ext;
	logic [UW-1:0]           uq [3];

	// Advance every stage unless a result waits on the output
	assign ctl.en   = !out_vld_q || out_ready;
	assign in_ready = ctl.en;

	vn3_sumsq u_sumsq (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.in_vld   (in_valid),
		.in_vec   (in_data),
		.out_vld  (sq_vld),
		.out_rad  (sq_rad),
		.out_side (sq_side)
	);

	vn3_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.in_vld   (sq_vld),
		.in_rad   (sq_rad),
		.in_side  (sq_side),
		.out_vld  (rt_vld),
		.out_root (rt_root),
		.out_side (rt_side)
	);

	vn3_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.in_vld   (rt_vld),
		.in_root  (rt_root),
		.in_side  (rt_side),
		.out_vld  (dv_vld),
		.out_root (dv_root),
		.out_side (dv_side),
		.out_quo  (dv_quo)
	);

	// Apply signs, saturate length, force zeros for the zero vector
	assign len_ext = XW'(dv_root >> vn3_pkg::ROOT_FRAC);

	for (genvar l = 0; l < 3; l++) begin : g_sign
		logic [UW-1:0] mag;
		assign mag   = UW'(dv_quo[l]);
		assign uq[l] = dv_side.neg[2-l] ? (UW'(0) - mag) : mag;
	end

	always_comb begin
		fmt.zero_vector = dv_side.zero;
		if (dv_side.zero) begin
			fmt.unit_x = '0;
			fmt.unit_y = '0;
			fmt.unit_z = '0;
			fmt.length = '0;
		end else begin
			fmt.unit_x = uq[0];
			fmt.unit_y = uq[1];
			fmt.unit_z = uq[2];
			fmt.length = ((len_ext >> vn3_pkg::LEN_W) != '0) ? '1
				: len_ext[vn3_pkg::LEN_W-1:0];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (ctl.en) begin
			out_vld_q <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			out_q <= fmt;
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

// ===== sim/vector_normalize_3d_tb.sv =====
// Testbench for vector_normalize_3d: length and unit vector of a 3D vector.
// Drives vectors through the valid/ready input channel and checks every result
// against an in-bench predictor; depends on vn3_pkg and the RTL.
`default_nettype none
module vector_normalize_3d_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM  = 1700;
	localparam int WDOG_MAX  = 20000;
	localparam int DRAIN_CYC = 200;
	localparam int MAX_SHOW  = 10;

	// idling phases
	typedef enum int {PH_NONE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} idle_phase_t;

	typedef struct {
		vn3_pkg::vec_in_t  vec;
		bit                known;
		vn3_pkg::vec_out_t res;
	} stim_row_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	vn3_pkg::vec_in_t  in_data;
	logic              out_valid;
	logic              out_ready;
	vn3_pkg::vec_out_t out_data;

	vn3_pkg::vec_out_t expected_q[$];
	int                mismatches;
	int                idle_cycles;
	bit                timed_out;
	idle_phase_t       phase;

	vector_normalize_3d i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// floor(sqrt(n)) by bit-serial trial
	function automatic logic [63:0] isqrt128(logic [127:0] n);
		logic [63:0] r;
		logic [63:0] c;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if ({64'd0, c} * {64'd0, c} <= n)
				r = c;
		end
		return r;
	endfunction

	// compute length and unit vector of one input vector
	function automatic vn3_pkg::vec_out_t normalize(vn3_pkg::vec_in_t v);
		vn3_pkg::vec_out_t o;
		logic [31:0]       mag[3];
		logic              neg[3];
		logic [127:0]      sum_sq;
		logic [63:0]       root;
		logic [127:0]      num;
		logic [63:0]       quo;
		logic [31:0]       unit[3];
		mag[0] = v.comp_x[31] ? -v.comp_x : v.comp_x;
		mag[1] = v.comp_y[31] ? -v.comp_y : v.comp_y;
		mag[2] = v.comp_z[31] ? -v.comp_z : v.comp_z;
		neg[0] = v.comp_x[31];
		neg[1] = v.comp_y[31];
		neg[2] = v.comp_z[31];
		o = '0;
		if (mag[0] == 0 && mag[1] == 0 && mag[2] == 0) begin
			o.zero_vector = 1'b1;
			return o;
		end
		sum_sq = '0;
		for (int i = 0; i < 3; i++)
			sum_sq += {96'd0, mag[i]} * {96'd0, mag[i]};
		root = isqrt128(sum_sq << 32);
		for (int i = 0; i < 3; i++) begin
			num = {96'd0, mag[i]} << 46;
			quo = 64'(num / {64'd0, root});
			unit[i] = neg[i] ? -quo[31:0] : quo[31:0];
		end
		o.unit_x = unit[0];
		o.unit_y = unit[1];
		o.unit_z = unit[2];
		o.length = (root >> 16) > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : 32'(root >> 16);
		return o;
	endfunction

	function automatic bit idle_draw(bit active);
		return active && ($urandom_range(99) < 68);
	endfunction

	function automatic logic [31:0] rand_comp();
		case ($urandom_range(5))
			0: return $urandom;
			1: return 32'($signed($urandom_range(2000)) - 1000);
			2: return $urandom >> $urandom_range(31);
			3: return -($urandom >> $urandom_range(31));
			4: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			default: return $urandom_range(3) == 0 ? 32'd0 : $urandom;
		endcase
	endfunction

	// watchdog and result checking
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_SHOW)
						$display("unexpected result %h", out_data);
				end else begin
					vn3_pkg::vec_out_t want;
					want = expected_q.pop_front();
					if (want.unit_x !== out_data.unit_x || want.unit_y !== out_data.unit_y ||
					    want.unit_z !== out_data.unit_z || want.length !== out_data.length ||
					    want.zero_vector !== out_data.zero_vector) begin
						mismatches++;
						if (mismatches <= MAX_SHOW)
							$display("mismatch: exp %h %h %h %h %b, got %h %h %h %h %b",
								want.unit_x, want.unit_y, want.unit_z, want.length,
								want.zero_vector, out_data.unit_x, out_data.unit_y,
								out_data.unit_z, out_data.length, out_data.zero_vector);
					end
				end
			end
		end
	end

	// receiver stalls by phase
	always @(negedge clk) begin
		out_ready <= !idle_draw(phase == PH_RECV_STALL || phase == PH_BOTH);
	end

	// hand one vector over and record its expected result
	task automatic send_vector(vn3_pkg::vec_in_t v, bit known, vn3_pkg::vec_out_t res);
		vn3_pkg::vec_out_t pred;
		// drop valid while the sender idles
		while (idle_draw(phase == PH_SEND_IDLE || phase == PH_BOTH)) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pred = normalize(v);
		if (known && pred != res) begin
			mismatches++;
			if (mismatches <= MAX_SHOW)
				$display("table row disagrees with predictor for %h", v);
		end
		expected_q.push_back(known ? res : pred);
		@(negedge clk);
	endtask

	// stop offering transfers
	task automatic release_input();
		in_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_empty();
		while (expected_q.size() != 0 && !timed_out)
			@(negedge clk);
	endtask

	initial begin
		stim_row_t        rows[$];
		stim_row_t        row;
		vn3_pkg::vec_in_t v;
		mismatches  = 0;
		idle_cycles = 0;
		timed_out   = 0;
		phase       = PH_NONE;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_data     = '0;
		out_ready   = 1'b1;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// directed rows: zero vector, unit axes, extremes, mixed signs
		row.known = 1; row.vec = '0; row.res = '0; row.res.zero_vector = 1; rows.push_back(row);
		row.vec = '{32'h0001_0000, 0, 0}; row.res = '{32'h4000_0000, 0, 0, 32'h0001_0000, 0};
		rows.push_back(row);
		row.vec = '{0, 32'hFFFF_0000, 0}; row.res = '{0, 32'hC000_0000, 0, 32'h0001_0000, 0};
		rows.push_back(row);
		row.vec = '{0, 0, 32'h8000_0000}; row.res = '{0, 0, 32'hC000_0000, 32'h8000_0000, 0};
		rows.push_back(row);
		row.vec = '{0, 0, 32'd1}; row.res = '{0, 0, 32'h4000_0000, 32'd1, 0};
		rows.push_back(row);
		row.known = 0;
		row.vec = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}; rows.push_back(row);
		row.vec = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}; rows.push_back(row);
		row.vec = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF}; rows.push_back(row);
		row.vec = '{32'd1, 32'd1, 32'd1}; rows.push_back(row);
		row.vec = '{32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF}; rows.push_back(row);
		row.vec = '{32'h0003_0000, 32'h0004_0000, 32'd0}; rows.push_back(row);
		row.vec = '{32'hFFFD_0000, 32'h0004_0000, 32'h000C_0000}; rows.push_back(row);
		row.vec = '{32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F}; rows.push_back(row);
		row.vec = '{32'd1, 32'h7FFF_FFFF, 32'd0}; rows.push_back(row);
		foreach (rows[i])
			send_vector(rows[i].vec, rows[i].known, rows[i].res);

		// random vectors across idling phases
		for (int n = 0; n < N_RANDOM && !timed_out; n++) begin
			if (n % 425 == 0) begin
				phase = idle_phase_t'(n / 425);
				if (n == 425) begin
					release_input();
					wait_empty();
				end
			end
			v.comp_x = rand_comp();
			v.comp_y = rand_comp();
			v.comp_z = rand_comp();
			if ($urandom_range(49) == 0)
				v = '0;
			send_vector(v, 0, '0);
		end
		release_input();
		wait_empty();
		repeat (DRAIN_CYC) @(negedge clk);
		if (!timed_out) begin
			if (mismatches == 0 && expected_q.size() == 0)
				$display("vector_normalize_3d_tb: PASS");
			else
				$display("vector_normalize_3d_tb: FAIL");
			$finish;
		end
	end

	// end the run if nothing transfers for too long
	always @(posedge clk) begin
		if (idle_cycles >= WDOG_MAX && !timed_out) begin
			timed_out = 1;
			$display("vector_normalize_3d_tb: FAIL");
			$finish;
		end
	end

endmodule
`default_nettype wire
